>>> rtl/rpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_pkg: shared types and constants of the permutation generator
// Field widths, request kinds and the status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package rpg_pkg;

  localparam int DEFAULT_MAX_LEN = 256;
  // entries beyond this are never addressed: the length register is 8 bits
  localparam int POOL_LIMIT      = 256;
  localparam int LEN_W           = 8;
  localparam int WORD_W          = 31;
  localparam int ELEM_W          = 8;
  localparam int CMP_W           = 9;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_DRAW  = 1'b1
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/rpg_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_mod_unit: bit-serial remainder unit
// Restoring reduction of the random word by the live pool count, one word
// bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rpg_mod_unit
  import rpg_pkg::*;
#(
  parameter int REM_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [WORD_W-1:0] dividend,
  input  logic [REM_W-1:0]  divisor,
  output div_status_t       status,
  output logic [REM_W-1:0]  rem
);

  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_W - 1);

  logic [WORD_W-1:0] word_sr;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic              done;
  logic [REM_W:0]    trial;
  logic              fits;

  assign trial = {rem, word_sr[WORD_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (load && !active) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !active) begin
      word_sr <= dividend;
      rem     <= '0;
    end else if (active) begin
      word_sr <= {word_sr[WORD_W-2:0], 1'b0};
      // shifted remainder stays below twice the divisor
      if (fits) begin
        rem <= REM_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[REM_W-1:0];
      end
    end
  end

  assign status.busy = active;
  assign status.done = done;

endmodule

>>> rtl/random_permutation_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_generator: Fisher-Yates (Durstenfeld) shuffle
// Draw: accept loads the bit-serial remainder unit; states S_RD_R and S_RD_TOP
//   then read the pool, and S_WRITE writes it on its one read, one write port.
// Start and a draw on an empty pool are taken in idle; empty draw strobes done next cycle.
// One item at a time; busy is high while a draw is in flight.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset (rst, synchronous) empties the pool and clears the length register.
// ----------------------------------------------------------------------------
module random_permutation_generator
  import rpg_pkg::*;
#(
  parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [WORD_W-1:0] random_word,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  output logic              done,
  output logic [ELEM_W-1:0] position,
  output logic [ELEM_W-1:0] element,
  output logic              last,
  output logic              exhausted
);

  localparam int POOL_DEPTH = (MAX_LEN < POOL_LIMIT) ? MAX_LEN : POOL_LIMIT;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int REM_W      = $clog2(POOL_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_RD_R   = 5'b00100,
    S_RD_TOP = 5'b01000,
    S_WRITE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [LEN_W-1:0]      perm_length;
  logic [REM_W-1:0]      remaining;
  logic [POOL_DEPTH-1:0] marks;
  logic [ELEM_W-1:0]     pool [POOL_DEPTH];
  logic [ELEM_W-1:0]     rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [ELEM_W-1:0]     picked;
  logic [ELEM_W-1:0]     moved;

  logic                  accept;
  logic                  div_load;
  div_status_t           div_status;
  logic [REM_W-1:0]      div_rem;
  logic [IDX_W-1:0]      r_idx;
  logic [IDX_W-1:0]      top_idx;
  logic [REM_W-1:0]      top;
  logic [CMP_W-1:0]      len_ext;
  logic [REM_W-1:0]      start_count;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign div_load = accept && (kind == KIND_DRAW) && (remaining != '0);

  assign top     = remaining - 1'b1;
  assign top_idx = top[IDX_W-1:0];
  assign r_idx   = div_rem[IDX_W-1:0];
  assign rd_addr = (state == S_RD_TOP) ? top_idx : r_idx;

  // unwritten entries hold their own index
  assign moved = marks[top_idx] ? rd_data : ELEM_W'(top_idx);

  assign len_ext     = CMP_W'(perm_length);
  assign start_count = (len_ext > CMP_W'(POOL_DEPTH)) ? REM_W'(POOL_DEPTH)
                                                      : REM_W'(len_ext);

  rpg_mod_unit #(
    .REM_W(REM_W)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .load    (div_load),
    .dividend(random_word),
    .divisor (remaining),
    .status  (div_status),
    .rem     (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (div_load) state_next = S_DIV;
      S_DIV:    if (div_status.done) state_next = S_RD_R;
      S_RD_R:   state_next = S_RD_TOP;
      S_RD_TOP: state_next = S_WRITE;
      S_WRITE:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      perm_length <= '0;
      remaining   <= '0;
      marks       <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr_en) begin
        perm_length <= cfg_wr_data;
      end
      if (accept && (kind == KIND_START)) begin
        marks     <= '0;
        remaining <= start_count;
      end
      if (accept && (kind == KIND_DRAW) && (remaining == '0)) begin
        done <= 1'b1;
      end
      if (state == S_WRITE) begin
        marks[r_idx] <= 1'b1;
        remaining    <= top;
        done         <= 1'b1;
      end
    end
  end

  // pool memory: one read, one write port
  always_ff @(posedge clk) begin
    rd_data <= pool[rd_addr];
    if (state == S_WRITE) begin
      pool[r_idx] <= moved;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD_TOP) begin
      picked <= marks[r_idx] ? rd_data : ELEM_W'(r_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_DRAW) && (remaining == '0)) begin
      position  <= '0;
      element   <= '0;
      last      <= 1'b0;
      exhausted <= 1'b1;
    end else if (state == S_WRITE) begin
      position  <= ELEM_W'(top_idx);
      element   <= picked;
      last      <= (top == '0);
      exhausted <= 1'b0;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while a draw is in flight");

  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    (done && exhausted) |-> (position == '0 && element == '0 && !last))
    else $error("exhausted result carries nonzero fields");

  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    div_load |=> (busy && div_status.busy))
    else $error("draw accepted but remainder unit not running");

  a_remaining_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> (remaining == $past(remaining) - 1'b1))
    else $error("pool count did not shrink by one");

endmodule
